[design/snfcs_pkg.sv]
`timescale 1ns / 1ps

package snfcs_pkg;

    // field widths of the request and result items
    localparam int OPCODE_W = 3;
    localparam int ADDR_W   = 24;
    localparam int BYTE_W   = 8;
    localparam int KIND_W   = 3;

    // defaults for the top level parameters
    localparam int DEF_PAGE_BYTES   = 256;
    localparam int DEF_ADDRESS_BITS = 24;

    // request queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // slot counter of the back end (longest sequence is nine slots)
    localparam int STEP_W = 4;

    // flash command bytes
    localparam logic [BYTE_W-1:0] CMD_PROGRAM = 8'h02;
    localparam logic [BYTE_W-1:0] CMD_READ    = 8'h03;
    localparam logic [BYTE_W-1:0] CMD_STATUS  = 8'h05;
    localparam logic [BYTE_W-1:0] CMD_WREN    = 8'h06;
    localparam logic [BYTE_W-1:0] CMD_ERASE4K = 8'h20;
    localparam logic [BYTE_W-1:0] CMD_READ_ID = 8'h9F;
    localparam logic [BYTE_W-1:0] RECV_FILL   = 8'hFF;
    localparam logic [BYTE_W-1:0] ZERO_BYTE   = 8'h00;

    // request opcodes
    typedef enum logic [OPCODE_W-1:0] {
        OP_READ   = 3'd0,
        OP_PROG   = 3'd1,
        OP_ERASE  = 3'd2,
        OP_ID     = 3'd3,
        OP_DATA   = 3'd4,
        OP_FINISH = 3'd5,
        OP_REPLY  = 3'd6
    } op_t;

    // result kinds
    typedef enum logic [KIND_W-1:0] {
        K_SEND = 3'd0,
        K_RECV = 3'd1,
        K_REL  = 3'd2,
        K_DONE = 3'd3,
        K_REJ  = 3'd4
    } kind_t;

    // slot sequences the back end plays out
    typedef enum logic [3:0] {
        SQ_REJ,
        SQ_READ,
        SQ_PROG,
        SQ_ERASE,
        SQ_ID,
        SQ_RECV,
        SQ_SEND,
        SQ_RELDONE,
        SQ_RELPOLL,
        SQ_RESUME
    } seq_t;

    typedef struct packed {
        seq_t              seq;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } desc_t;

    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] obyte;
        logic              last;
    } slot_t;

    function automatic slot_t mk_slot(kind_t k, logic [BYTE_W-1:0] b, logic l);
        slot_t s;
        s.kind  = k;
        s.obyte = b;
        s.last  = l;
        return s;
    endfunction

    // one result slot of a sequence at a given step
    function automatic slot_t seq_slot(desc_t d, logic [STEP_W-1:0] step);
        slot_t s;
        logic [BYTE_W-1:0] a2;
        logic [BYTE_W-1:0] a1;
        logic [BYTE_W-1:0] a0;
        a2 = d.addr[23:16];
        a1 = d.addr[15:8];
        a0 = d.addr[7:0];
        s  = mk_slot(K_REJ, ZERO_BYTE, 1'b1);
        unique case (d.seq)
            SQ_READ:
            begin
                unique case (step)
                    4'd0:    s = mk_slot(K_SEND, CMD_READ, 1'b0);
                    4'd1:    s = mk_slot(K_SEND, a2, 1'b0);
                    4'd2:    s = mk_slot(K_SEND, a1, 1'b0);
                    default: s = mk_slot(K_SEND, a0, 1'b1);
                endcase
            end
            SQ_PROG:
            begin
                unique case (step)
                    4'd0:    s = mk_slot(K_SEND, CMD_WREN, 1'b0);
                    4'd1:    s = mk_slot(K_REL, ZERO_BYTE, 1'b0);
                    4'd2:    s = mk_slot(K_SEND, CMD_PROGRAM, 1'b0);
                    4'd3:    s = mk_slot(K_SEND, a2, 1'b0);
                    4'd4:    s = mk_slot(K_SEND, a1, 1'b0);
                    default: s = mk_slot(K_SEND, a0, 1'b1);
                endcase
            end
            SQ_ERASE:
            begin
                unique case (step)
                    4'd0:    s = mk_slot(K_SEND, CMD_WREN, 1'b0);
                    4'd1:    s = mk_slot(K_REL, ZERO_BYTE, 1'b0);
                    4'd2:    s = mk_slot(K_SEND, CMD_ERASE4K, 1'b0);
                    4'd3:    s = mk_slot(K_SEND, a2, 1'b0);
                    4'd4:    s = mk_slot(K_SEND, a1, 1'b0);
                    4'd5:    s = mk_slot(K_SEND, a0, 1'b0);
                    4'd6:    s = mk_slot(K_REL, ZERO_BYTE, 1'b0);
                    4'd7:    s = mk_slot(K_SEND, CMD_STATUS, 1'b0);
                    default: s = mk_slot(K_RECV, RECV_FILL, 1'b1);
                endcase
            end
            SQ_ID:   s = mk_slot(K_SEND, CMD_READ_ID, 1'b1);
            SQ_RECV: s = mk_slot(K_RECV, RECV_FILL, 1'b1);
            SQ_SEND: s = mk_slot(K_SEND, d.data, 1'b1);
            SQ_RELDONE:
            begin
                unique case (step)
                    4'd0:    s = mk_slot(K_REL, ZERO_BYTE, 1'b0);
                    default: s = mk_slot(K_DONE, ZERO_BYTE, 1'b1);
                endcase
            end
            SQ_RELPOLL:
            begin
                unique case (step)
                    4'd0:    s = mk_slot(K_REL, ZERO_BYTE, 1'b0);
                    4'd1:    s = mk_slot(K_SEND, CMD_STATUS, 1'b0);
                    default: s = mk_slot(K_RECV, RECV_FILL, 1'b1);
                endcase
            end
            SQ_RESUME:
            begin
                unique case (step)
                    4'd0:    s = mk_slot(K_REL, ZERO_BYTE, 1'b0);
                    4'd1:    s = mk_slot(K_SEND, CMD_WREN, 1'b0);
                    4'd2:    s = mk_slot(K_REL, ZERO_BYTE, 1'b0);
                    4'd3:    s = mk_slot(K_SEND, CMD_PROGRAM, 1'b0);
                    4'd4:    s = mk_slot(K_SEND, a2, 1'b0);
                    4'd5:    s = mk_slot(K_SEND, a1, 1'b0);
                    4'd6:    s = mk_slot(K_SEND, a0, 1'b0);
                    default: s = mk_slot(K_SEND, d.data, 1'b1);
                endcase
            end
            default: s = mk_slot(K_REJ, ZERO_BYTE, 1'b1);
        endcase
        return s;
    endfunction

endpackage

[design/snfcs_if.sv]
`timescale 1ns / 1ps

// request channel
interface snfcs_req_if;
    logic                                valid;
    logic                                ready;
    logic [snfcs_pkg::OPCODE_W-1:0]      opcode;
    logic [snfcs_pkg::ADDR_W-1:0]        address;
    logic [snfcs_pkg::BYTE_W-1:0]        value;

    modport source (output valid, output opcode, output address, output value,
                    input ready);
    modport sink   (input valid, input opcode, input address, input value,
                    output ready);
endinterface

// result channel
interface snfcs_res_if;
    logic                                valid;
    logic                                ready;
    logic [snfcs_pkg::KIND_W-1:0]        kind;
    logic [snfcs_pkg::BYTE_W-1:0]        out_byte;
    logic                                last;

    modport source (output valid, output kind, output out_byte, output last,
                    input ready);
    modport sink   (input valid, input kind, input out_byte, input last,
                    output ready);
endinterface

// configuration write channel
interface snfcs_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[design/snfcs_front.sv]
`timescale 1ns / 1ps

module snfcs_front #(
    parameter int PAGE_BYTES   = snfcs_pkg::DEF_PAGE_BYTES,
    parameter int ADDRESS_BITS = snfcs_pkg::DEF_ADDRESS_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    snfcs_req_if.sink          req,
    snfcs_cfg_if.sink          cfg,
    output logic               push_valid,
    output snfcs_pkg::desc_t   push_desc,
    input  logic               push_ready
);
    import snfcs_pkg::*;

    // page size is a power of two; the page offset is the low bits
    localparam int PAGE_BITS = $clog2(PAGE_BYTES);

    typedef enum logic [2:0] {
        M_IDLE,
        M_READ,
        M_ID,
        M_PROG,
        M_POLL_END,
        M_POLL_SPLIT
    } mode_t;

    mode_t                   mode_reg,  mode_next;
    logic [ADDRESS_BITS-1:0] addr_reg,  addr_next;
    logic [BYTE_W-1:0]       held_reg,  held_next;
    logic                    fhd_reg,   fhd_next;
    logic                    split_reg;

    logic                    accept;
    logic [ADDRESS_BITS-1:0] in_addr;
    logic [ADDRESS_BITS-1:0] addr_inc;
    logic                    page_edge;

    // low 24 bits of an address counter, zero-extended when narrower
    function automatic logic [ADDR_W-1:0] to_slot_addr(logic [ADDRESS_BITS-1:0] a);
        logic [31:0] w;
        w = 32'(a);
        return w[ADDR_W-1:0];
    endfunction

    assign accept    = req.valid && push_ready;
    assign req.ready = push_ready;
    assign cfg.ready = 1'b1;
    assign in_addr   = ADDRESS_BITS'(req.address);
    assign addr_inc  = addr_reg + 1'b1;
    assign page_edge = (addr_reg[PAGE_BITS-1:0] == '0);

    // classify the request and work out the next state
    always_comb
    begin
        mode_next      = mode_reg;
        addr_next      = addr_reg;
        held_next      = held_reg;
        fhd_next       = fhd_reg;
        push_desc.seq  = SQ_REJ;
        push_desc.addr = to_slot_addr(addr_reg);
        push_desc.data = req.value;
        unique case (req.opcode)
            OP_READ:
            begin
                if (mode_reg == M_IDLE)
                begin
                    push_desc.seq  = SQ_READ;
                    push_desc.addr = to_slot_addr(in_addr);
                    addr_next      = in_addr;
                    mode_next      = M_READ;
                end
            end
            OP_PROG:
            begin
                if (mode_reg == M_IDLE)
                begin
                    push_desc.seq  = SQ_PROG;
                    push_desc.addr = to_slot_addr(in_addr);
                    addr_next      = in_addr;
                    fhd_next       = 1'b0;
                    mode_next      = M_PROG;
                end
            end
            OP_ERASE:
            begin
                if (mode_reg == M_IDLE)
                begin
                    push_desc.seq  = SQ_ERASE;
                    push_desc.addr = to_slot_addr(in_addr);
                    mode_next      = M_POLL_END;
                end
            end
            OP_ID:
            begin
                if (mode_reg == M_IDLE)
                begin
                    push_desc.seq = SQ_ID;
                    mode_next     = M_ID;
                end
            end
            OP_DATA:
            begin
                if (mode_reg == M_READ)
                begin
                    push_desc.seq = SQ_RECV;
                    addr_next     = addr_inc;
                end
                else if (mode_reg == M_ID)
                begin
                    push_desc.seq = SQ_RECV;
                end
                else if (mode_reg == M_PROG)
                begin
                    if (split_reg && fhd_reg && page_edge)
                    begin
                        // page crossing: close the frame and hold the byte
                        push_desc.seq = SQ_RELPOLL;
                        held_next     = req.value;
                        mode_next     = M_POLL_SPLIT;
                    end
                    else
                    begin
                        push_desc.seq = SQ_SEND;
                        addr_next     = addr_inc;
                        fhd_next      = 1'b1;
                    end
                end
            end
            OP_FINISH:
            begin
                if (mode_reg == M_READ || mode_reg == M_ID)
                begin
                    push_desc.seq = SQ_RELDONE;
                    mode_next     = M_IDLE;
                end
                else if (mode_reg == M_PROG)
                begin
                    push_desc.seq = SQ_RELPOLL;
                    mode_next     = M_POLL_END;
                end
            end
            OP_REPLY:
            begin
                if (mode_reg == M_POLL_END || mode_reg == M_POLL_SPLIT)
                begin
                    if (req.value[0])
                    begin
                        // still busy: poll again
                        push_desc.seq = SQ_RELPOLL;
                    end
                    else if (mode_reg == M_POLL_END)
                    begin
                        push_desc.seq = SQ_RELDONE;
                        fhd_next      = 1'b0;
                        mode_next     = M_IDLE;
                    end
                    else
                    begin
                        // reopen the program frame with the held byte
                        push_desc.seq  = SQ_RESUME;
                        push_desc.data = held_reg;
                        addr_next      = addr_inc;
                        fhd_next       = 1'b1;
                        mode_next      = M_PROG;
                    end
                end
            end
            default: push_desc.seq = SQ_REJ;
        endcase
    end

    assign push_valid = req.valid;

    // state registers and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_IDLE;
            addr_reg  <= '0;
            held_reg  <= '0;
            fhd_reg   <= 1'b0;
            split_reg <= 1'b1;
        end
        else
        begin
            if (cfg.valid)
            begin
                split_reg <= cfg.data;
            end
            if (accept)
            begin
                mode_reg <= mode_next;
                addr_reg <= addr_next;
                held_reg <= held_next;
                fhd_reg  <= fhd_next;
            end
        end
    end

endmodule

[design/snfcs_queue.sv]
`timescale 1ns / 1ps

module snfcs_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    input  snfcs_pkg::desc_t   push_desc,
    output logic               push_ready,
    input  logic               pop,
    output snfcs_pkg::desc_t   head_desc,
    output logic               head_valid
);
    import snfcs_pkg::*;

    desc_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wptr_reg;
    logic [QPTR_W-1:0] rptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_desc  = mem_reg[rptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wptr_reg] <= push_desc;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[design/snfcs_back.sv]
`timescale 1ns / 1ps

module snfcs_back (
    input  logic               clk,
    input  logic               rst_n,
    input  snfcs_pkg::desc_t   head_desc,
    input  logic               head_valid,
    output logic               pop,
    snfcs_res_if.source        rsp
);
    import snfcs_pkg::*;

    logic              busy_reg;
    desc_t             desc_reg;
    logic [STEP_W-1:0] step_reg;
    slot_t             slot;
    logic              fire;
    logic              done;
    logic              load;

    // current slot of the sequence in hand
    assign slot         = seq_slot(desc_reg, step_reg);
    assign rsp.valid    = busy_reg;
    assign rsp.kind     = slot.kind;
    assign rsp.out_byte = slot.obyte;
    assign rsp.last     = slot.last;

    assign fire = busy_reg && rsp.ready;
    assign done = fire && slot.last;
    assign load = (!busy_reg || done) && head_valid;
    assign pop  = load;

    // descriptor register and slot counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            desc_reg <= '{seq: SQ_REJ, addr: '0, data: '0};
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
            desc_reg <= head_desc;
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
        else if (fire)
        begin
            step_reg <= step_reg + 1'b1;
        end
    end

endmodule

[design/spi_nor_flash_command_sequencer_core.sv]
`timescale 1ns / 1ps

// Channel  Dir  Handshake        Payload
// req      in   valid / ready    opcode[2:0], address[23:0], value[7:0]
// rsp      out  valid / ready    kind[2:0], out_byte[7:0], last
// cfg      in   valid / ready    data (split_on_page)
//
// A request is taken whenever the four-entry request queue has room; its
// results leave at one slot per cycle while rsp.ready is high, 1 to 9 slots per
// request, paced by the slot counter of the back end.
// Reset (rst_n low, asynchronous) returns to idle, empties the queue and sets
// split_on_page to 1. A stalled rsp fills the queue, then req.ready drops.
// cfg.ready is always high.

module spi_nor_flash_command_sequencer_core #(
    parameter int PAGE_BYTES   = snfcs_pkg::DEF_PAGE_BYTES,
    parameter int ADDRESS_BITS = snfcs_pkg::DEF_ADDRESS_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    snfcs_req_if.sink   req,
    snfcs_res_if.source rsp,
    snfcs_cfg_if.sink   cfg
);
    import snfcs_pkg::*;

    logic  push_valid;
    desc_t push_desc;
    logic  push_ready;
    logic  pop;
    desc_t head_desc;
    logic  head_valid;

    // request decode and mode tracking
    snfcs_front #(
        .PAGE_BYTES   (PAGE_BYTES),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .cfg        (cfg),
        .push_valid (push_valid),
        .push_desc  (push_desc),
        .push_ready (push_ready)
    );

    // decoupling queue
    snfcs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_desc  (push_desc),
        .push_ready (push_ready),
        .pop        (pop),
        .head_desc  (head_desc),
        .head_valid (head_valid)
    );

    // slot sequencer
    snfcs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_desc  (head_desc),
        .head_valid (head_valid),
        .pop        (pop),
        .rsp        (rsp)
    );

endmodule

[sim/tb_spi_nor_flash_command_sequencer_core.sv]
`timescale 1ns / 1ps

module tb_spi_nor_flash_command_sequencer_core;
    import snfcs_pkg::*;

    localparam int PAGE_SIZE   = DEF_PAGE_BYTES;
    localparam int QUIET_LIMIT = 1000;
    localparam int DIR_ROWS    = 23;

    // opcode with no meaning to the block
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 3'd7;

    // sequencer modes as the predictor tracks them
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_ID,
        ST_PROG,
        ST_POLL_DONE,
        ST_POLL_SPLIT
    } flash_mode_t;

    // one directed request; fixed marks a row whose single result is typed in
    typedef struct packed {
        logic [OPCODE_W-1:0] opc;
        logic [ADDR_W-1:0]   addr;
        logic [BYTE_W-1:0]   val;
        logic                fixed;
        kind_t               fkind;
        logic [BYTE_W-1:0]   fbyte;
    } dir_row_t;

    localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
        // rejects in idle, unknown opcode first
        '{OP_UNUSED, 24'hFFFFFF, 8'hFF, 1'b1, K_REJ, ZERO_BYTE},
        '{OP_DATA,   24'h000000, 8'h00, 1'b1, K_REJ, ZERO_BYTE},
        '{OP_REPLY,  24'h000000, 8'h00, 1'b1, K_REJ, ZERO_BYTE},
        '{OP_FINISH, 24'h000000, 8'h00, 1'b1, K_REJ, ZERO_BYTE},
        // identify, start refused while busy, one id byte, close
        '{OP_ID,     24'h000000, 8'h00, 1'b1, K_SEND, CMD_READ_ID},
        '{OP_READ,   24'h000000, 8'h00, 1'b1, K_REJ, ZERO_BYTE},
        '{OP_DATA,   24'h000000, 8'h00, 1'b1, K_RECV, RECV_FILL},
        '{OP_FINISH, 24'h000000, 8'h00, 1'b0, K_REJ, ZERO_BYTE},
        // read at the top of the address space, wraps on the data slot
        '{OP_READ,   24'hFFFFFF, 8'h00, 1'b0, K_REJ, ZERO_BYTE},
        '{OP_DATA,   24'h000000, 8'h00, 1'b0, K_REJ, ZERO_BYTE},
        '{OP_FINISH, 24'h000000, 8'h00, 1'b0, K_REJ, ZERO_BYTE},
        // program across a page boundary, busy once, resume, finish
        '{OP_PROG,   24'h0000FE, 8'h00, 1'b0, K_REJ, ZERO_BYTE},
        '{OP_DATA,   24'h000000, 8'h00, 1'b0, K_REJ, ZERO_BYTE},
        '{OP_DATA,   24'h000000, 8'hFF, 1'b0, K_REJ, ZERO_BYTE},
        '{OP_DATA,   24'h000000, 8'hA5, 1'b0, K_REJ, ZERO_BYTE},
        '{OP_DATA,   24'h000000, 8'h5A, 1'b1, K_REJ, ZERO_BYTE},
        '{OP_REPLY,  24'h000000, 8'h01, 1'b0, K_REJ, ZERO_BYTE},
        '{OP_REPLY,  24'h000000, 8'hFE, 1'b0, K_REJ, ZERO_BYTE},
        '{OP_FINISH, 24'h000000, 8'h00, 1'b0, K_REJ, ZERO_BYTE},
        '{OP_REPLY,  24'h000000, 8'h00, 1'b0, K_REJ, ZERO_BYTE},
        // sector erase with one busy poll
        '{OP_ERASE,  24'hABCDEF, 8'h00, 1'b0, K_REJ, ZERO_BYTE},
        '{OP_REPLY,  24'h000000, 8'hFF, 1'b0, K_REJ, ZERO_BYTE},
        '{OP_REPLY,  24'h000000, 8'h00, 1'b0, K_REJ, ZERO_BYTE}
    };

    logic clk;
    logic rst_n;

    snfcs_req_if req_ch ();
    snfcs_res_if rsp_ch ();
    snfcs_cfg_if cfg_ch ();

    spi_nor_flash_command_sequencer_core uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // predicted sequencer state
    flash_mode_t       cur_mode    = ST_IDLE;
    logic [ADDR_W-1:0] cur_addr    = '0;
    logic [BYTE_W-1:0] held_data   = '0;
    logic              page_dirty  = 1'b0;
    logic              split_pages = 1'b1;

    slot_t step_slots[$];
    slot_t pending_slots[$];

    int mismatch_count = 0;
    int live_items     = 0;
    int quiet_cycles   = 0;
    int rx_hold        = 0;
    bit idle_on        = 1'b1;
    bit calm_tx        = 1'b0;
    bit calm_rx        = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input logic [BYTE_W-1:0] got,
                                   input logic [BYTE_W-1:0] want);
        $display("mismatch: %s got %0h want %0h at %0t", what, got, want, $time);
        mismatch_count++;
    endtask

    function automatic void put_slot(input kind_t k, input logic [BYTE_W-1:0] b);
        slot_t s;
        s.kind  = k;
        s.obyte = b;
        s.last  = 1'b0;
        step_slots.push_back(s);
    endfunction

    // three address bytes, most significant first
    function automatic void put_addr(input logic [ADDR_W-1:0] a);
        put_slot(K_SEND, a[23:16]);
        put_slot(K_SEND, a[15:8]);
        put_slot(K_SEND, a[7:0]);
    endfunction

    function automatic void put_poll();
        put_slot(K_SEND, CMD_STATUS);
        put_slot(K_RECV, RECV_FILL);
    endfunction

    function automatic void put_wren();
        put_slot(K_SEND, CMD_WREN);
        put_slot(K_REL, ZERO_BYTE);
    endfunction

    // slots one request causes; advances the predicted state
    function automatic void flash_slots_for(input logic [OPCODE_W-1:0] opc,
                                            input logic [ADDR_W-1:0] addr,
                                            input logic [BYTE_W-1:0] val);
        slot_t tail;
        step_slots.delete();
        case (opc)
            OP_READ:
            begin
                if (cur_mode != ST_IDLE)
                    put_slot(K_REJ, ZERO_BYTE);
                else
                begin
                    put_slot(K_SEND, CMD_READ);
                    put_addr(addr);
                    cur_addr = addr;
                    cur_mode = ST_READ;
                end
            end
            OP_PROG:
            begin
                if (cur_mode != ST_IDLE)
                    put_slot(K_REJ, ZERO_BYTE);
                else
                begin
                    put_wren();
                    put_slot(K_SEND, CMD_PROGRAM);
                    put_addr(addr);
                    cur_addr   = addr;
                    page_dirty = 1'b0;
                    cur_mode   = ST_PROG;
                end
            end
            OP_ERASE:
            begin
                if (cur_mode != ST_IDLE)
                    put_slot(K_REJ, ZERO_BYTE);
                else
                begin
                    put_wren();
                    put_slot(K_SEND, CMD_ERASE4K);
                    put_addr(addr);
                    put_slot(K_REL, ZERO_BYTE);
                    put_poll();
                    cur_mode = ST_POLL_DONE;
                end
            end
            OP_ID:
            begin
                if (cur_mode != ST_IDLE)
                    put_slot(K_REJ, ZERO_BYTE);
                else
                begin
                    put_slot(K_SEND, CMD_READ_ID);
                    cur_mode = ST_ID;
                end
            end
            OP_DATA:
            begin
                if (cur_mode == ST_READ)
                begin
                    put_slot(K_RECV, RECV_FILL);
                    cur_addr = cur_addr + 1'b1;
                end
                else if (cur_mode == ST_ID)
                    put_slot(K_RECV, RECV_FILL);
                else if (cur_mode == ST_PROG)
                begin
                    // first byte of a new page in a frame with data: hold it, poll
                    if (split_pages && page_dirty && (cur_addr % PAGE_SIZE) == 0)
                    begin
                        put_slot(K_REL, ZERO_BYTE);
                        put_poll();
                        held_data = val;
                        cur_mode  = ST_POLL_SPLIT;
                    end
                    else
                    begin
                        put_slot(K_SEND, val);
                        cur_addr   = cur_addr + 1'b1;
                        page_dirty = 1'b1;
                    end
                end
                else
                    put_slot(K_REJ, ZERO_BYTE);
            end
            OP_FINISH:
            begin
                if (cur_mode == ST_READ || cur_mode == ST_ID)
                begin
                    put_slot(K_REL, ZERO_BYTE);
                    put_slot(K_DONE, ZERO_BYTE);
                    cur_mode = ST_IDLE;
                end
                else if (cur_mode == ST_PROG)
                begin
                    put_slot(K_REL, ZERO_BYTE);
                    put_poll();
                    cur_mode = ST_POLL_DONE;
                end
                else
                    put_slot(K_REJ, ZERO_BYTE);
            end
            OP_REPLY:
            begin
                if (cur_mode != ST_POLL_DONE && cur_mode != ST_POLL_SPLIT)
                    put_slot(K_REJ, ZERO_BYTE);
                else
                begin
                    put_slot(K_REL, ZERO_BYTE);
                    if (val[0])
                        put_poll();
                    else if (cur_mode == ST_POLL_DONE)
                    begin
                        put_slot(K_DONE, ZERO_BYTE);
                        page_dirty = 1'b0;
                        cur_mode   = ST_IDLE;
                    end
                    else
                    begin
                        // reopen the program frame at the new page
                        put_wren();
                        put_slot(K_SEND, CMD_PROGRAM);
                        put_addr(cur_addr);
                        put_slot(K_SEND, held_data);
                        cur_addr   = cur_addr + 1'b1;
                        page_dirty = 1'b1;
                        cur_mode   = ST_PROG;
                    end
                end
            end
            default: put_slot(K_REJ, ZERO_BYTE);
        endcase
        tail      = step_slots.pop_back();
        tail.last = 1'b1;
        step_slots.push_back(tail);
    endfunction

    // drive one item, queue its expectations, wait for acceptance
    task automatic issue(input logic [OPCODE_W-1:0] opc, input logic [ADDR_W-1:0] addr,
                         input logic [BYTE_W-1:0] val, input logic fixed,
                         input kind_t fkind, input logic [BYTE_W-1:0] fbyte);
        slot_t s;
        flash_slots_for(opc, addr, val);
        if (step_slots[0].kind != K_REJ)
            live_items++;
        if (fixed)
        begin
            s.kind  = fkind;
            s.obyte = fbyte;
            s.last  = 1'b1;
            pending_slots.push_back(s);
        end
        else
            foreach (step_slots[i])
                pending_slots.push_back(step_slots[i]);

        req_ch.valid   <= 1'b1;
        req_ch.opcode  <= opc;
        req_ch.address <= addr;
        req_ch.value   <= val;
        do
            @(posedge clk);
        while (!req_ch.ready);

        // sender idle burst
        if (idle_on && !calm_tx && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        if ($urandom_range(0, 31) == 0)
            calm_tx = !calm_tx;
    endtask

    task automatic hold_until_drained();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_slots.size() != 0);
    endtask

    // register write once the block has gone quiet
    task automatic write_split(input logic v);
        hold_until_drained();
        repeat (4) @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= v;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        split_pages = v;
    endtask

    // mostly well-formed transactions driven by the predicted mode, some noise
    task automatic pick_request(output logic [OPCODE_W-1:0] opc,
                                output logic [ADDR_W-1:0] addr,
                                output logic [BYTE_W-1:0] val);
        int roll;
        int where;
        roll  = $urandom_range(0, 99);
        where = $urandom_range(0, 9);
        addr  = ADDR_W'($urandom);
        val   = BYTE_W'($urandom);
        // bias starts toward page ends and the top of the address space
        if (where >= 8)
            addr[ADDR_W-1:4] = '1;
        else if (where >= 5)
            addr[7:4] = 4'hF;
        if (roll < 6)
            opc = OPCODE_W'($urandom_range(0, 7));
        else
        begin
            case (cur_mode)
                ST_IDLE:         opc = OPCODE_W'($urandom_range(OP_READ, OP_ID));
                ST_READ, ST_ID:  opc = (roll < 85) ? OP_DATA : OP_FINISH;
                ST_PROG:         opc = (roll < 92) ? OP_DATA : OP_FINISH;
                default:
                begin
                    opc    = OP_REPLY;
                    val[0] = (roll < 35);
                end
            endcase
        end
    endtask

    task automatic run_random(input int goal, input int drain_at);
        logic [OPCODE_W-1:0] opc;
        logic [ADDR_W-1:0]   addr;
        logic [BYTE_W-1:0]   val;
        int                  stop_at;
        stop_at = live_items + goal;
        while (live_items < stop_at)
        begin
            if (drain_at > 0 && live_items == stop_at - goal + drain_at)
            begin
                hold_until_drained();
                drain_at = 0;
            end
            pick_request(opc, addr, val);
            issue(opc, addr, val, 1'b0, K_REJ, ZERO_BYTE);
        end
        // close whatever transaction is open
        while (cur_mode != ST_IDLE)
        begin
            val = BYTE_W'($urandom);
            if (cur_mode == ST_POLL_DONE || cur_mode == ST_POLL_SPLIT)
            begin
                val[0] = 1'b0;
                issue(OP_REPLY, ADDR_W'($urandom), val, 1'b0, K_REJ, ZERO_BYTE);
            end
            else
                issue(OP_FINISH, ADDR_W'($urandom), val, 1'b0, K_REJ, ZERO_BYTE);
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        slot_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_slots.size() == 0)
                report_mismatch("result with nothing pending, byte", rsp_ch.out_byte, ZERO_BYTE);
            else
            begin
                want = pending_slots.pop_front();
                if (rsp_ch.kind !== want.kind)
                    report_mismatch("kind", BYTE_W'(rsp_ch.kind), BYTE_W'(want.kind));
                if (rsp_ch.out_byte !== want.obyte)
                    report_mismatch("out_byte", rsp_ch.out_byte, want.obyte);
                if (rsp_ch.last !== want.last)
                    report_mismatch("last", BYTE_W'(rsp_ch.last), BYTE_W'(want.last));
            end
        end
    end

    // receiver stalls in bursts, rx_hold counting down each burst
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else if (rx_hold > 0)
        begin
            rsp_ch.ready <= 1'b0;
            rx_hold      <= rx_hold - 1;
        end
        else if (idle_on && !calm_rx && $urandom_range(0, 7) == 0)
        begin
            rsp_ch.ready <= 1'b0;
            rx_hold      <= $urandom_range(0, 8);
        end
        else
            rsp_ch.ready <= 1'b1;
        if ($urandom_range(0, 63) == 0)
            calm_rx <= !calm_rx;
    end

    // watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // stimulus
    initial
    begin
        dir_row_t row;
        rst_n          <= 1'b0;
        req_ch.valid   <= 1'b0;
        req_ch.opcode  <= OP_READ;
        req_ch.address <= '0;
        req_ch.value   <= '0;
        cfg_ch.valid   <= 1'b0;
        cfg_ch.data    <= 1'b1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, page splitting at its reset value
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            row = DIR_TAB[i];
            issue(row.opc, row.addr, row.val, row.fixed, row.fkind, row.fbyte);
        end

        write_split(1'b0);
        run_random(60, 0);
        write_split(1'b1);
        run_random(50, 25);
        write_split(1'b0);
        run_random(35, 0);

        // last part without idling on either side
        write_split(1'b1);
        idle_on = 1'b0;
        run_random(45, 0);

        hold_until_drained();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[files.f]
design/snfcs_pkg.sv
design/snfcs_if.sv
design/snfcs_front.sv
design/snfcs_queue.sv
design/snfcs_back.sv
design/spi_nor_flash_command_sequencer_core.sv
sim/tb_spi_nor_flash_command_sequencer_core.sv
